FILE: hw/rtl/qcr_pkg.sv
package qcr_pkg;

    localparam int RenormPeriod = 97;
    localparam int CntW         = 7;
    localparam int DataW        = 16;
    localparam int FracBits     = 14;
    localparam int ProdW        = 2 * DataW;
    localparam int AccW         = ProdW + 2;
    localparam int MagW         = ProdW + 1;
    localparam int NormShift    = 28;
    localparam int NumW         = DataW + NormShift;
    localparam int StepW        = 6;
    localparam int MulSteps     = 16;
    localparam int SqSteps      = 4;
    localparam int DivSteps     = NumW;
    localparam int SatW         = AccW - FracBits;

    localparam logic [1:0] IdxX = 2'd0;
    localparam logic [1:0] IdxY = 2'd1;
    localparam logic [1:0] IdxZ = 2'd2;
    localparam logic [1:0] IdxW = 2'd3;

    localparam logic signed [DataW-1:0] OneQ14  = 16'sd16384;
    localparam logic signed [DataW-1:0] MaxQ14  = 16'sd32767;
    localparam logic signed [DataW-1:0] MinQ14  = -16'sd32768;

    typedef logic signed [DataW-1:0] t_q14;

    typedef struct packed {
        t_q14 spin_x;
        t_q14 spin_y;
        t_q14 spin_z;
        t_q14 spin_w;
    } t_spin;

    typedef struct packed {
        t_q14 orient_x;
        t_q14 orient_y;
        t_q14 orient_z;
        t_q14 orient_w;
        logic renormalized;
    } t_orient;

    typedef struct packed {
        logic [1:0] s_idx;
        logic [1:0] o_idx;
        logic       neg;
    } t_term;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic       sq_en;
        logic [3:0] step;
        logic [1:0] idx;
        logic       div_load;
        logic       div_step;
        logic       div_store;
        logic       publish;
        logic       renorm;
    } t_cmd;

    typedef struct packed {
        logic mag_zero;
        logic out_busy;
    } t_stat;

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_MUL       = 9'b000000010,
        S_DRAIN     = 9'b000000100,
        S_SQ        = 9'b000001000,
        S_SQ_DRAIN  = 9'b000010000,
        S_DIV_LOAD  = 9'b000100000,
        S_DIV_STEP  = 9'b001000000,
        S_DIV_STORE = 9'b010000000,
        S_DONE      = 9'b100000000
    } t_state;

    // component = k[3:2], term = k[1:0]
    function automatic t_term term_sel(input logic [3:0] k);
        t_term t;
        case (k)
            4'd0:    t = '{IdxX, IdxW, 1'b0};
            4'd1:    t = '{IdxW, IdxX, 1'b0};
            4'd2:    t = '{IdxZ, IdxY, 1'b0};
            4'd3:    t = '{IdxY, IdxZ, 1'b1};
            4'd4:    t = '{IdxY, IdxW, 1'b0};
            4'd5:    t = '{IdxW, IdxY, 1'b0};
            4'd6:    t = '{IdxX, IdxZ, 1'b0};
            4'd7:    t = '{IdxZ, IdxX, 1'b1};
            4'd8:    t = '{IdxZ, IdxW, 1'b0};
            4'd9:    t = '{IdxW, IdxZ, 1'b0};
            4'd10:   t = '{IdxY, IdxX, 1'b0};
            4'd11:   t = '{IdxX, IdxY, 1'b1};
            4'd12:   t = '{IdxW, IdxW, 1'b0};
            4'd13:   t = '{IdxX, IdxX, 1'b1};
            4'd14:   t = '{IdxY, IdxY, 1'b1};
            4'd15:   t = '{IdxZ, IdxZ, 1'b1};
            default: t = '{IdxX, IdxX, 1'b0};
        endcase
        return t;
    endfunction

    function automatic t_q14 sat16(input logic signed [SatW-1:0] v);
        t_q14 r;
        if (v > SatW'(MaxQ14)) begin
            r = MaxQ14;
        end else if (v < SatW'(MinQ14)) begin
            r = MinQ14;
        end else begin
            r = v[DataW-1:0];
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/qcr_if.sv
interface qcr_spin_if;
    logic          valid;
    logic          ready;
    qcr_pkg::t_spin data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface qcr_orient_if;
    logic            valid;
    logic            ready;
    qcr_pkg::t_orient data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/quaternion_compose_renorm.sv
// Composes each incoming incremental rotation onto a held orientation quaternion
// (signed Q2.14, identity after reset) and returns the new orientation on the output
// channel. One shared 16x16 multiplier does the 16 products in sequence, and one
// update in every 98 also runs the normalization: the multiplier squares the four
// components, and then a restoring divider divides each of the four components by
// that sum of squares in turn. The input is taken only between updates; a finished
// result sits in the output register so the next input can be taken while it waits.
module quaternion_compose_renorm (
    input  logic                i_clk,
    input  logic                i_rst_n,
    qcr_spin_if.sink            i_spin,
    qcr_orient_if.source        o_orient
);

    qcr_pkg::t_cmd  cmd;
    qcr_pkg::t_stat stat;
    logic           in_ready;
    logic           out_valid;
    qcr_pkg::t_orient out_data;

    qcr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_spin.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    qcr_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_spin      (i_spin.data),
        .i_cmd       (cmd),
        .i_out_ready (o_orient.ready),
        .o_stat      (stat),
        .o_out       (out_data),
        .o_out_valid (out_valid)
    );

    assign i_spin.ready   = in_ready;
    assign o_orient.valid = out_valid;
    assign o_orient.data  = out_data;

endmodule

FILE: hw/rtl/qcr_ctrl.sv
module qcr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  qcr_pkg::t_stat i_stat,
    output qcr_pkg::t_cmd  o_cmd
);

    qcr_pkg::t_state r_state, n_state;
    logic [qcr_pkg::StepW-1:0] r_step, n_step;
    logic [1:0]                r_comp, n_comp;
    logic [qcr_pkg::CntW-1:0]  r_cnt, n_cnt;
    logic                      r_renorm, n_renorm;
    logic [qcr_pkg::CntW:0]    cnt_inc;

    assign cnt_inc = {1'b0, r_cnt} + (qcr_pkg::CntW+1)'(1);

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_comp     = r_comp;
        n_cnt      = r_cnt;
        n_renorm   = r_renorm;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.step   = r_step[3:0];
        o_cmd.idx    = (r_state == qcr_pkg::S_SQ) ? r_step[1:0] : r_comp;
        o_cmd.renorm = r_renorm;
        case (r_state)
            qcr_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = qcr_pkg::S_MUL;
                    n_step     = '0;
                    if (cnt_inc > (qcr_pkg::CntW+1)'(qcr_pkg::RenormPeriod)) begin
                        n_cnt    = '0;
                        n_renorm = 1'b1;
                    end else begin
                        n_cnt    = cnt_inc[qcr_pkg::CntW-1:0];
                        n_renorm = 1'b0;
                    end
                end
            end
            qcr_pkg::S_MUL: begin
                o_cmd.mul_en = 1'b1;
                if (r_step == qcr_pkg::StepW'(qcr_pkg::MulSteps - 1)) begin
                    n_state = qcr_pkg::S_DRAIN;
                    n_step  = '0;
                end else begin
                    n_step = r_step + qcr_pkg::StepW'(1);
                end
            end
            qcr_pkg::S_DRAIN: begin
                n_state = r_renorm ? qcr_pkg::S_SQ : qcr_pkg::S_DONE;
            end
            qcr_pkg::S_SQ: begin
                o_cmd.sq_en = 1'b1;
                if (r_step == qcr_pkg::StepW'(qcr_pkg::SqSteps - 1)) begin
                    n_state = qcr_pkg::S_SQ_DRAIN;
                    n_step  = '0;
                end else begin
                    n_step = r_step + qcr_pkg::StepW'(1);
                end
            end
            qcr_pkg::S_SQ_DRAIN: begin
                n_state = qcr_pkg::S_DIV_LOAD;
                n_comp  = '0;
            end
            qcr_pkg::S_DIV_LOAD: begin
                if (i_stat.mag_zero) begin
                    n_state = qcr_pkg::S_DONE;
                end else begin
                    o_cmd.div_load = 1'b1;
                    n_step         = '0;
                    n_state        = qcr_pkg::S_DIV_STEP;
                end
            end
            qcr_pkg::S_DIV_STEP: begin
                o_cmd.div_step = 1'b1;
                if (r_step == qcr_pkg::StepW'(qcr_pkg::DivSteps - 1)) begin
                    n_state = qcr_pkg::S_DIV_STORE;
                end else begin
                    n_step = r_step + qcr_pkg::StepW'(1);
                end
            end
            qcr_pkg::S_DIV_STORE: begin
                o_cmd.div_store = 1'b1;
                if (r_comp == qcr_pkg::IdxW) begin
                    n_state = qcr_pkg::S_DONE;
                end else begin
                    n_comp  = r_comp + 2'd1;
                    n_state = qcr_pkg::S_DIV_LOAD;
                end
            end
            qcr_pkg::S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.publish = 1'b1;
                    n_state       = qcr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = qcr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= qcr_pkg::S_IDLE;
            r_step   <= '0;
            r_comp   <= '0;
            r_cnt    <= '0;
            r_renorm <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_comp   <= n_comp;
            r_cnt    <= n_cnt;
            r_renorm <= n_renorm;
        end
    end

endmodule

FILE: hw/rtl/qcr_datapath.sv
module qcr_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  qcr_pkg::t_spin   i_spin,
    input  qcr_pkg::t_cmd    i_cmd,
    input  logic             i_out_ready,
    output qcr_pkg::t_stat   o_stat,
    output qcr_pkg::t_orient o_out,
    output logic             o_out_valid
);

    qcr_pkg::t_q14 r_spin   [4];
    qcr_pkg::t_q14 r_orient [4];
    qcr_pkg::t_q14 r_res    [4];

    logic signed [qcr_pkg::ProdW-1:0] r_prod;
    logic                             r_p_mul;
    logic                             r_p_sq;
    logic [3:0]                       r_p_step;
    logic signed [qcr_pkg::AccW-1:0]  r_acc;
    logic [qcr_pkg::MagW-1:0]         r_mag;
    logic [qcr_pkg::MagW-1:0]         r_rem;
    logic [qcr_pkg::NumW-1:0]         r_num;
    logic                             r_neg;
    qcr_pkg::t_orient                 r_out;
    logic                             r_out_valid;

    qcr_pkg::t_term                   sel;
    qcr_pkg::t_term                   p_sel;
    qcr_pkg::t_q14                    mul_a;
    qcr_pkg::t_q14                    mul_b;
    logic signed [qcr_pkg::AccW-1:0]  prod_ext;
    logic signed [qcr_pkg::AccW-1:0]  acc_base;
    logic signed [qcr_pkg::AccW-1:0]  acc_sum;
    qcr_pkg::t_q14                    acc_q;
    logic [qcr_pkg::MagW-1:0]         mag_base;
    logic [qcr_pkg::MagW-1:0]         mag_sum;
    logic [qcr_pkg::MagW:0]           rem_sh;
    logic [qcr_pkg::MagW:0]           rem_sub;
    logic                             rem_ge;
    qcr_pkg::t_q14                    ld_val;
    logic [qcr_pkg::DataW-1:0]        ld_mag;
    logic                             q_big;
    qcr_pkg::t_q14                    div_q;

    assign sel   = qcr_pkg::term_sel(i_cmd.step);
    assign p_sel = qcr_pkg::term_sel(r_p_step);
    assign mul_a = i_cmd.sq_en ? r_res[i_cmd.idx] : r_spin[sel.s_idx];
    assign mul_b = i_cmd.sq_en ? r_res[i_cmd.idx] : r_orient[sel.o_idx];

    // product accumulation, floor by dropping low bits, saturate
    assign prod_ext = {{(qcr_pkg::AccW-qcr_pkg::ProdW){r_prod[qcr_pkg::ProdW-1]}}, r_prod};
    assign acc_base = (r_p_step[1:0] == 2'd0) ? '0 : r_acc;
    assign acc_sum  = p_sel.neg ? acc_base - prod_ext : acc_base + prod_ext;
    assign acc_q    = qcr_pkg::sat16(acc_sum[qcr_pkg::AccW-1:qcr_pkg::FracBits]);

    // sum of squares
    assign mag_base = (r_p_step[1:0] == 2'd0) ? '0 : r_mag;
    assign mag_sum  = mag_base + {1'b0, r_prod};

    // restoring divider, one quotient bit per cycle
    assign rem_sh  = {r_rem, r_num[qcr_pkg::NumW-1]};
    assign rem_ge  = rem_sh >= {1'b0, r_mag};
    assign rem_sub = rem_sh - {1'b0, r_mag};

    assign ld_val = r_res[i_cmd.idx];
    assign ld_mag = ld_val[qcr_pkg::DataW-1] ? 16'(-ld_val) : 16'(ld_val);

    assign q_big = |r_num[qcr_pkg::NumW-1:qcr_pkg::DataW-1];

    always_comb begin
        if (r_neg) begin
            div_q = q_big ? qcr_pkg::MinQ14 : -qcr_pkg::t_q14'(r_num[qcr_pkg::DataW-1:0]);
        end else begin
            div_q = q_big ? qcr_pkg::MaxQ14 : qcr_pkg::t_q14'(r_num[qcr_pkg::DataW-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_spin[0] <= i_spin.spin_x;
            r_spin[1] <= i_spin.spin_y;
            r_spin[2] <= i_spin.spin_z;
            r_spin[3] <= i_spin.spin_w;
        end
        if (i_cmd.mul_en || i_cmd.sq_en) begin
            r_prod   <= mul_a * mul_b;
            r_p_step <= i_cmd.sq_en ? {2'd0, i_cmd.idx} : i_cmd.step;
        end
        if (r_p_mul) begin
            r_acc <= acc_sum;
            if (r_p_step[1:0] == 2'd3) begin
                r_res[r_p_step[3:2]] <= acc_q;
            end
        end
        if (r_p_sq) begin
            r_mag <= mag_sum;
        end
        if (i_cmd.div_load) begin
            r_rem <= '0;
            r_num <= {ld_mag, {qcr_pkg::NormShift{1'b0}}};
            r_neg <= ld_val[qcr_pkg::DataW-1];
        end
        if (i_cmd.div_step) begin
            r_rem <= rem_ge ? rem_sub[qcr_pkg::MagW-1:0] : rem_sh[qcr_pkg::MagW-1:0];
            r_num <= {r_num[qcr_pkg::NumW-2:0], rem_ge};
        end
        if (i_cmd.div_store) begin
            r_res[i_cmd.idx] <= div_q;
        end
        if (i_cmd.publish) begin
            r_out <= '{r_res[0], r_res[1], r_res[2], r_res[3], i_cmd.renorm};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_mul     <= 1'b0;
            r_p_sq      <= 1'b0;
            r_out_valid <= 1'b0;
            r_orient[0] <= '0;
            r_orient[1] <= '0;
            r_orient[2] <= '0;
            r_orient[3] <= qcr_pkg::OneQ14;
        end else begin
            r_p_mul <= i_cmd.mul_en;
            r_p_sq  <= i_cmd.sq_en;
            if (i_cmd.publish) begin
                r_orient    <= r_res;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.mag_zero = (r_mag == '0);
    assign o_stat.out_busy = r_out_valid && !i_out_ready;
    assign o_out           = r_out;
    assign o_out_valid     = r_out_valid;

endmodule

FILE: hw/rtl/qcr_checker.sv
module qcr_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input qcr_pkg::t_orient i_out_data
);

    // held result must not be dropped
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("output result dropped or changed while stalled");

    assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // no result appears right after an input transfer
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result appeared one cycle after input transfer");

    // one item at a time
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while an update is in progress");

endmodule

bind quaternion_compose_renorm qcr_checker u_qcr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_spin.valid),
    .i_in_ready  (i_spin.ready),
    .i_out_valid (o_orient.valid),
    .i_out_ready (o_orient.ready),
    .i_out_data  (o_orient.data)
);
